// ===== hw/rtl/modexp_pkg.sv =====
// Shared types, constants and the microcode program of the modular exponentiation block.
package modexp_pkg;

  // Fixed field widths
  localparam int unsigned BASE_W   = 63;
  localparam int unsigned EXP_W    = 63;
  localparam int unsigned MODCFG_W = 31;
  localparam int unsigned RESULT_W = 31;

  // Parameter defaults
  localparam int unsigned EXP_BITS_DEF = 63;
  localparam int unsigned MOD_BITS_DEF = 31;

  localparam logic [MODCFG_W-1:0] MODULUS_RESET = 31'd1000000007;

  // Reducer shifts a full base word through; a product always fits in it
  localparam int unsigned RED_W = BASE_W;
  localparam int unsigned CNT_W = $clog2(RED_W);

  // Step counter
  localparam int unsigned PC_W = 4;

  localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] STEP_ZCHK     = 4'd1;
  localparam logic [PC_W-1:0] STEP_RED_BASE = 4'd2;
  localparam logic [PC_W-1:0] STEP_SQ_INIT  = 4'd3;
  localparam logic [PC_W-1:0] STEP_BIT_TEST = 4'd4;
  localparam logic [PC_W-1:0] STEP_MUL_ACC  = 4'd5;
  localparam logic [PC_W-1:0] STEP_RED_ACC  = 4'd6;
  localparam logic [PC_W-1:0] STEP_ACC_WB   = 4'd7;
  localparam logic [PC_W-1:0] STEP_E_SHIFT  = 4'd8;
  localparam logic [PC_W-1:0] STEP_MUL_SQ   = 4'd9;
  localparam logic [PC_W-1:0] STEP_RED_SQ   = 4'd10;
  localparam logic [PC_W-1:0] STEP_SQ_WB    = 4'd11;
  localparam logic [PC_W-1:0] STEP_OUT_ACC  = 4'd12;
  localparam logic [PC_W-1:0] STEP_RET_A    = 4'd13;
  localparam logic [PC_W-1:0] STEP_OUT_ONE  = 4'd14;
  localparam logic [PC_W-1:0] STEP_RET_B    = 4'd15;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RSTEP,
    OP_MUL_ACC,
    OP_MUL_SQ,
    OP_ACC_FROM_R,
    OP_SQ_FROM_R,
    OP_E_SHIFT,
    OP_OUT_ACC,
    OP_OUT_ONE
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_E_ZERO,
    C_BIT_CLR,
    C_E_LAST,
    C_RED_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic in_accept;
    logic e_zero;
    logic bit_clr;
    logic e_last;
    logic red_more;
    logic out_busy;
  } flags_t;

  // Microcode ROM
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      STEP_WAIT:     w = '{op: OP_LOAD,       cond: C_NO_ACCEPT, target: STEP_WAIT};
      STEP_ZCHK:     w = '{op: OP_NOP,        cond: C_E_ZERO,    target: STEP_OUT_ONE};
      STEP_RED_BASE: w = '{op: OP_RSTEP,      cond: C_RED_MORE,  target: STEP_RED_BASE};
      STEP_SQ_INIT:  w = '{op: OP_SQ_FROM_R,  cond: C_NEXT,      target: STEP_WAIT};
      STEP_BIT_TEST: w = '{op: OP_NOP,        cond: C_BIT_CLR,   target: STEP_E_SHIFT};
      STEP_MUL_ACC:  w = '{op: OP_MUL_ACC,    cond: C_NEXT,      target: STEP_WAIT};
      STEP_RED_ACC:  w = '{op: OP_RSTEP,      cond: C_RED_MORE,  target: STEP_RED_ACC};
      STEP_ACC_WB:   w = '{op: OP_ACC_FROM_R, cond: C_NEXT,      target: STEP_WAIT};
      STEP_E_SHIFT:  w = '{op: OP_E_SHIFT,    cond: C_E_LAST,    target: STEP_OUT_ACC};
      STEP_MUL_SQ:   w = '{op: OP_MUL_SQ,     cond: C_NEXT,      target: STEP_WAIT};
      STEP_RED_SQ:   w = '{op: OP_RSTEP,      cond: C_RED_MORE,  target: STEP_RED_SQ};
      STEP_SQ_WB:    w = '{op: OP_SQ_FROM_R,  cond: C_ALWAYS,    target: STEP_BIT_TEST};
      STEP_OUT_ACC:  w = '{op: OP_OUT_ACC,    cond: C_OUT_BUSY,  target: STEP_OUT_ACC};
      STEP_RET_A:    w = '{op: OP_NOP,        cond: C_ALWAYS,    target: STEP_WAIT};
      STEP_OUT_ONE:  w = '{op: OP_OUT_ONE,    cond: C_OUT_BUSY,  target: STEP_OUT_ONE};
      STEP_RET_B:    w = '{op: OP_NOP,        cond: C_ALWAYS,    target: STEP_WAIT};
      default:       w = '{op: OP_NOP,        cond: C_ALWAYS,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/modexp_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module modexp_seq
  import modexp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output op_e    op_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;
  logic            taken;

  // Control word for the current step
  assign ctrl = ucode(pc_q);
  assign op_o = ctrl.op;

  // Jump condition
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_ACCEPT: taken = !flags_i.in_accept;
      C_E_ZERO:    taken = flags_i.e_zero;
      C_BIT_CLR:   taken = flags_i.bit_clr;
      C_E_LAST:    taken = flags_i.e_last;
      C_RED_MORE:  taken = flags_i.red_more;
      C_OUT_BUSY:  taken = flags_i.out_busy;
      default:     taken = 1'b0;
    endcase
  end

  assign pc_d = taken ? ctrl.target : pc_q + PC_W'(1);

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef ASSERT_OFF
  // an accepted word always moves on to the exponent check
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_i.in_accept |=> pc_q == STEP_ZCHK)
    else $error("accepted word did not advance to exponent check");

  // a blocked result step holds its place
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pc_q == STEP_OUT_ACC || pc_q == STEP_OUT_ONE) && flags_i.out_busy)
    |=> $stable(pc_q))
    else $error("result step left while output register busy");
`endif

endmodule

// ===== hw/rtl/modexp_dp.sv =====
// Datapath: modulus register, operand registers, multiplier, serial reducer and output register.
module modexp_dp
  import modexp_pkg::*;
#(
  parameter int unsigned EXP_BITS = EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = MOD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  op_e                 op_i,
  input  logic                cfg_we_i,
  input  logic [MODCFG_W-1:0] cfg_modulus_i,
  input  logic                in_valid_i,
  input  logic [BASE_W-1:0]   base_i,
  input  logic [EXP_W-1:0]    exponent_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RESULT_W-1:0] power_result_o,
  output flags_t              flags_o
);

  localparam int unsigned PROD_W = 2 * MOD_BITS;

  logic [MOD_BITS-1:0] mod_q, mod_d;
  logic [MOD_BITS-1:0] m_eff;
  logic [RED_W-1:0]    sh_q, sh_d;
  logic [MOD_BITS-1:0] r_q, r_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] sq_q, sq_d;
  logic [EXP_BITS-1:0] e_q, e_d;
  logic                out_valid_q, out_valid_d;
  logic [RESULT_W-1:0] res_q, res_d;

  logic [MOD_BITS:0]   r_ext, m_ext, r_sub;
  logic [MOD_BITS-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic                out_busy;
  logic                accept;

  // A zero modulus behaves as one
  assign m_eff = (mod_q == '0) ? MOD_BITS'(1) : mod_q;

  // Modulus register
  assign mod_d = cfg_we_i ? cfg_modulus_i[MOD_BITS-1:0] : mod_q;

  // Restoring reduction step: shift one dividend bit into the remainder
  assign r_ext = {r_q, sh_q[RED_W-1]};
  assign m_ext = {1'b0, m_eff};
  assign r_sub = r_ext - m_ext;

  // One multiplier, operand chosen by the op; result lands in the reducer shifter
  assign mul_a = (op_i == OP_MUL_SQ) ? sq_q : acc_q;
  assign mul_b = sq_q;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign out_busy = out_valid_q && out_stall_i;
  assign accept   = in_valid_i && (op_i == OP_LOAD);

  // Datapath operation decode
  always_comb begin
    sh_d        = sh_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    e_d         = e_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (op_i) inside
      OP_LOAD: begin
        if (accept) begin
          sh_d  = base_i;
          r_d   = '0;
          cnt_d = '0;
          acc_d = MOD_BITS'(1);
          e_d   = exponent_i[EXP_BITS-1:0];
        end
      end
      OP_RSTEP: begin
        r_d   = (r_ext >= m_ext) ? r_sub[MOD_BITS-1:0] : r_ext[MOD_BITS-1:0];
        sh_d  = sh_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_MUL_ACC, OP_MUL_SQ: begin
        sh_d  = RED_W'(prod);
        r_d   = '0;
        cnt_d = '0;
      end
      OP_ACC_FROM_R: acc_d = r_q;
      OP_SQ_FROM_R:  sq_d  = r_q;
      OP_E_SHIFT:    e_d   = e_q >> 1;
      OP_OUT_ACC: begin
        if (!out_busy) begin
          res_d       = RESULT_W'(acc_q);
          out_valid_d = 1'b1;
        end
      end
      OP_OUT_ONE: begin
        if (!out_busy) begin
          res_d       = RESULT_W'(1);
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Status for the sequencer
  assign flags_o.in_accept = accept;
  assign flags_o.e_zero    = (e_q == '0);
  assign flags_o.bit_clr   = !e_q[0];
  assign flags_o.e_last    = ((e_q >> 1) == '0);
  assign flags_o.red_more  = (cnt_q != CNT_W'(RED_W - 1));
  assign flags_o.out_busy  = out_busy;

  assign out_valid_o    = out_valid_q;
  assign power_result_o = res_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= MODULUS_RESET[MOD_BITS-1:0];
      out_valid_q <= 1'b0;
    end else begin
      mod_q       <= mod_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    r_q   <= r_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    e_q   <= e_d;
    res_q <= res_d;
  end

`ifndef ASSERT_OFF
  // a finished reduction leaves a remainder below the modulus
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_ACC_FROM_R || op_i == OP_SQ_FROM_R) |-> r_q < m_eff)
    else $error("remainder not reduced below modulus");

  // the running square is reduced whenever the exponent advances
  a_sq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_E_SHIFT) |-> sq_q < m_eff)
    else $error("square out of range");

  // the product written out is always reduced
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_OUT_ACC) |-> acc_q < m_eff)
    else $error("accumulator out of range at output");
`endif

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block.
// Computes base ** exponent mod modulus by square and multiply, scanning the exponent from
// its least significant bit. A small microcode program drives one 31x31 multiplier and a
// one-bit-per-cycle restoring reducer; each modular multiply is a multiply, 63 reduction
// steps and a write-back. An item holds the block for its fixed work (wait, exponent check,
// 63 base reduction steps, square load, output, return) plus, for every exponent bit up to
// the highest set one, a test and a shift, a multiply when the bit is set and a squaring on
// all but that highest bit. A zero exponent returns 1 and frees the block after the wait,
// exponent check, output and return steps. The output step also waits while an earlier
// result is still stalled in the output register. One word is worked on at a time; a new
// word is accepted while the previous result still waits in the output register.
// A modulus of zero acts as one. Write the modulus only while the block is idle.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned EXP_BITS = EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = MOD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MODCFG_W-1:0] cfg_modulus_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [BASE_W-1:0]   base_i,
  input  logic [EXP_W-1:0]    exponent_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RESULT_W-1:0] power_result_o
);

  op_e    op;
  flags_t flags;

  // Words are taken only at the wait step
  assign in_stall_o = (op != OP_LOAD);

  modexp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  modexp_dp #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .cfg_we_i       (cfg_we_i),
    .cfg_modulus_i  (cfg_modulus_i),
    .in_valid_i     (in_valid_i),
    .base_i         (base_i),
    .exponent_i     (exponent_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .power_result_o (power_result_o),
    .flags_o        (flags)
  );

endmodule
